>>> design/ist_pkg.sv
// Shared types and codes for the interval set table.
package ist_pkg;

	typedef logic [2:0] op_t;

	localparam op_t OP_INCLUDE  = 3'd0;
	localparam op_t OP_EXCLUDE  = 3'd1;
	localparam op_t OP_TEST     = 3'd2;
	localparam op_t OP_READ     = 3'd3;
	localparam op_t OP_SHIFT_UP = 3'd4;
	localparam op_t OP_SHIFT_DN = 3'd5;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_SHIFT = 2'd2;

	typedef struct packed {
		op_t         op;
		logic [31:0] range_low;
		logic [31:0] range_high;
		logic [31:0] shift_amount;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        is_member;
		logic        entry_valid;
		logic [31:0] entry_begin;
		logic [31:0] entry_end;
		logic [4:0]  range_count;
		logic [31:0] covered_total;
	} rsp_t;

	// per-cell update command
	typedef enum logic [3:0] {
		CA_HOLD,
		CA_LOAD,
		CA_FROM_LEFT,
		CA_FROM_RIGHT,
		CA_MERGE_INC,
		CA_ABSORB,
		CA_END_LO,
		CA_BEG_HI,
		CA_SPLIT_HI,
		CA_ADD,
		CA_SUB
	} cell_act_t;

	// bound compares reported by each cell
	typedef struct packed {
		logic end_lt_lo;
		logic end_le_lo;
		logic beg_le_hi;
		logic beg_lt_hi;
		logic lo_gt_beg;
		logic hi_lt_end;
		logic holds_lo;
	} cell_flags_t;

endpackage

>>> design/ist_cell.sv
// One table slot: holds a range, compares it against the request, sums lengths down the row.
module ist_cell #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ist_pkg::cell_act_t     act,
	input  logic [VALUE_BITS-1:0]  lo,
	input  logic [VALUE_BITS-1:0]  hi,
	input  logic [VALUE_BITS-1:0]  amt,
	input  logic [VALUE_BITS-1:0]  left_beg,
	input  logic [VALUE_BITS-1:0]  left_end,
	input  logic [VALUE_BITS-1:0]  right_beg,
	input  logic [VALUE_BITS-1:0]  right_end,
	input  logic                   in_use,
	input  logic [31:0]            sum_in,
	output logic [VALUE_BITS-1:0]  cur_beg,
	output logic [VALUE_BITS-1:0]  cur_end,
	output ist_pkg::cell_flags_t   flags,
	output logic [31:0]            sum_out
);
	import ist_pkg::*;

	logic [VALUE_BITS-1:0] beg_q;
	logic [VALUE_BITS-1:0] end_q;
	logic [VALUE_BITS-1:0] len;
	logic [31:0]           sum_q;

	always_ff @(posedge clk) begin
		unique case (act)
			CA_HOLD: ;
			CA_LOAD: begin
				beg_q <= lo;
				end_q <= hi;
			end
			CA_FROM_LEFT: begin
				beg_q <= left_beg;
				end_q <= left_end;
			end
			CA_FROM_RIGHT: begin
				beg_q <= right_beg;
				end_q <= right_end;
			end
			CA_MERGE_INC: begin
				beg_q <= (lo < beg_q) ? lo : beg_q;
				end_q <= (hi > end_q) ? hi : end_q;
			end
			CA_ABSORB:   end_q <= (right_end > end_q) ? right_end : end_q;
			CA_END_LO:   end_q <= lo;
			CA_BEG_HI:   beg_q <= hi;
			CA_SPLIT_HI: begin
				beg_q <= hi;
				end_q <= left_end;
			end
			CA_ADD: begin
				beg_q <= beg_q + amt;
				end_q <= end_q + amt;
			end
			CA_SUB: begin
				beg_q <= beg_q - amt;
				end_q <= end_q - amt;
			end
			default: ;
		endcase
	end

	assign len = end_q - beg_q;

	// running total ripples one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			sum_q <= sum_in + (in_use ? 32'(len) : 32'd0);
		end
	end

	assign cur_beg = beg_q;
	assign cur_end = end_q;
	assign sum_out = sum_q;

	assign flags.end_lt_lo = end_q < lo;
	assign flags.end_le_lo = end_q <= lo;
	assign flags.beg_le_hi = beg_q <= hi;
	assign flags.beg_lt_hi = beg_q < hi;
	assign flags.lo_gt_beg = lo > beg_q;
	assign flags.hi_lt_end = hi < end_q;
	assign flags.holds_lo  = (beg_q <= lo) && (lo < end_q);

endmodule

>>> design/interval_set_table.sv
// Interval set table: sorted disjoint half-open ranges held in a row of cells.
// Every request passes S_EVAL, S_ACT and S_DEL (which removes one range per step) to S_DONE;
// include and exclude also wait in S_SETTLE, letting the length sum ripple through the
// cell row. One request in flight at a time.
// Reset clears the range count and the sum row; slot contents are undefined until written.
module interval_set_table #(
	parameter int unsigned MAX_RANGES = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ist_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ist_pkg::rsp_t rsp
);
	import ist_pkg::*;

	localparam int unsigned IW = $clog2(MAX_RANGES + 1);
	localparam int unsigned SW = $clog2(MAX_RANGES + 2);
	localparam logic [VALUE_BITS-1:0] VMASK = {VALUE_BITS{1'b1}};

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_ACT    = 6'b000100,
		S_DEL    = 6'b001000,
		S_SETTLE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		P_NONE,
		P_INSERT,
		P_MERGE,
		P_SPLIT,
		P_TRIM,
		P_ADD,
		P_SUB
	} plan_t;

	state_t         state_q;
	req_t           req_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;
	logic [IW-1:0]  cnt_q;
	plan_t          plan_q;
	logic [IW-1:0]  i_q;
	logic [IW-1:0]  j_q;
	logic [IW-1:0]  del_pos_q;
	logic [IW-1:0]  del_cnt_q;
	logic           merge_q;
	logic [SW-1:0]  settle_q;
	status_t        status_q;
	logic           member_q;
	logic           ev_q;
	logic [31:0]    eb_q;
	logic [31:0]    ee_q;

	logic [VALUE_BITS-1:0] lo;
	logic [VALUE_BITS-1:0] hi;
	logic [VALUE_BITS-1:0] amt;

	logic [VALUE_BITS-1:0] beg_w [MAX_RANGES];
	logic [VALUE_BITS-1:0] end_w [MAX_RANGES];
	logic [VALUE_BITS-1:0] beg_x [MAX_RANGES+2];
	logic [VALUE_BITS-1:0] end_x [MAX_RANGES+2];
	cell_flags_t           flags_w [MAX_RANGES];
	cell_act_t             act_w [MAX_RANGES];
	logic [31:0]           sum_c [MAX_RANGES+1];
	logic [MAX_RANGES-1:0] vld;

	// evaluation results
	logic [MAX_RANGES-1:0] lmask;
	logic [MAX_RANGES-1:0] rmask;
	logic [MAX_RANGES-1:0] l_oh;
	logic [MAX_RANGES-1:0] r_oh;
	logic [MAX_RANGES-1:0] fa_vec;
	logic [IW-1:0]         i_c;
	logic [IW-1:0]         j_c;
	logic                  split_c;
	logic                  fa_c;
	logic                  fb_c;
	logic                  member_c;
	logic [VALUE_BITS-1:0] rd_beg;
	logic [VALUE_BITS-1:0] rd_end;
	logic [VALUE_BITS-1:0] last_end;
	logic                  rd_ok;
	logic                  up_over;
	logic                  dn_under;
	logic                  full;

	plan_t                 plan_c;
	status_t               status_c;
	logic [IW-1:0]         del_pos_c;
	logic [IW-1:0]         del_cnt_c;
	logic                  merge_c;
	logic [IW-1:0]         a_c;
	logic [IW-1:0]         b_c;

	assign lo  = req_q.range_low[VALUE_BITS-1:0];
	assign hi  = req_q.range_high[VALUE_BITS-1:0];
	assign amt = req_q.shift_amount[VALUE_BITS-1:0];

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		beg_x[0]            = '0;
		end_x[0]            = '0;
		beg_x[MAX_RANGES+1] = '0;
		end_x[MAX_RANGES+1] = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			beg_x[k+1] = beg_w[k];
			end_x[k+1] = end_w[k];
			vld[k]     = IW'(k) < cnt_q;
		end
	end

	assign sum_c[0] = '0;

	for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
		ist_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.act       (act_w[g]),
			.lo        (lo),
			.hi        (hi),
			.amt       (amt),
			.left_beg  (beg_x[g]),
			.left_end  (end_x[g]),
			.right_beg (beg_x[g+2]),
			.right_end (end_x[g+2]),
			.in_use    (vld[g]),
			.sum_in    (sum_c[g]),
			.cur_beg   (beg_w[g]),
			.cur_end   (end_w[g]),
			.flags     (flags_w[g]),
			.sum_out   (sum_c[g+1])
		);
	end

	// locate the span of affected slots and gather per-op answers
	always_comb begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (req_q.op == OP_INCLUDE) begin
				lmask[k] = vld[k] & flags_w[k].end_lt_lo;
				rmask[k] = vld[k] & flags_w[k].beg_le_hi;
			end else begin
				lmask[k] = vld[k] & flags_w[k].end_le_lo;
				rmask[k] = vld[k] & flags_w[k].beg_lt_hi;
			end
		end
		l_oh = ~lmask & {lmask[MAX_RANGES-2:0], 1'b1};
		r_oh = ~rmask & {rmask[MAX_RANGES-2:0], 1'b1};
		i_c      = (&lmask) ? IW'(MAX_RANGES) : '0;
		j_c      = (&rmask) ? IW'(MAX_RANGES) : '0;
		split_c  = 1'b0;
		fa_c     = 1'b0;
		fb_c     = 1'b0;
		member_c = 1'b0;
		rd_beg   = '0;
		rd_end   = '0;
		last_end = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (l_oh[k]) i_c = i_c | IW'(k);
			if (r_oh[k]) j_c = j_c | IW'(k);
		end
		for (int k = 0; k < MAX_RANGES; k++) begin
			fa_vec[k] = (IW'(k) == i_c) & flags_w[k].lo_gt_beg;
			fa_c      = fa_c | fa_vec[k];
			split_c   = split_c | (fa_vec[k] & flags_w[k].hi_lt_end);
			fb_c      = fb_c | ((IW'(k) == (j_c - IW'(1))) & flags_w[k].hi_lt_end & ~fa_vec[k]);
			member_c  = member_c | (vld[k] & flags_w[k].holds_lo);
			if (32'(k) == req_q.range_low) begin
				rd_beg = rd_beg | beg_w[k];
				rd_end = rd_end | end_w[k];
			end
			if (IW'(k + 1) == cnt_q) last_end = last_end | end_w[k];
		end
		split_c  = split_c & (j_c == (i_c + IW'(1)));
		rd_ok    = req_q.range_low < 32'(cnt_q);
		up_over  = (33'(last_end) + 33'(req_q.shift_amount)) > 33'(VMASK);
		dn_under = 32'(beg_w[0]) < req_q.shift_amount;
		full     = (cnt_q == IW'(MAX_RANGES));
	end

	always_comb begin
		plan_c    = P_NONE;
		status_c  = ST_OK;
		del_pos_c = '0;
		del_cnt_c = '0;
		merge_c   = 1'b0;
		a_c       = i_c + IW'(fa_c);
		b_c       = j_c - IW'(fb_c);
		unique case (req_q.op)
			OP_INCLUDE: begin
				if (lo < hi) begin
					if (i_c == j_c) begin
						if (full) status_c = ST_FULL;
						else plan_c = P_INSERT;
					end else begin
						plan_c    = P_MERGE;
						del_pos_c = i_c + IW'(1);
						del_cnt_c = j_c - i_c - IW'(1);
						merge_c   = 1'b1;
					end
				end
			end
			OP_EXCLUDE: begin
				if (lo < hi && i_c != j_c) begin
					if (split_c) begin
						if (full) status_c = ST_FULL;
						else plan_c = P_SPLIT;
					end else begin
						plan_c    = P_TRIM;
						del_pos_c = a_c;
						del_cnt_c = (b_c > a_c) ? (b_c - a_c) : '0;
					end
				end
			end
			OP_SHIFT_UP: begin
				if (cnt_q != '0) begin
					if (up_over) status_c = ST_SHIFT;
					else plan_c = P_ADD;
				end
			end
			OP_SHIFT_DN: begin
				if (cnt_q != '0) begin
					if (dn_under) status_c = ST_SHIFT;
					else plan_c = P_SUB;
				end
			end
			default: ;
		endcase
	end

	// per-cell commands: every cell decides from its own position, its own flags and the registered plan
	always_comb begin
		for (int k = 0; k < MAX_RANGES; k++) begin
			act_w[k] = CA_HOLD;
			if (state_q == S_ACT) begin
				case (plan_q)
					P_INSERT: begin
						if (IW'(k) > i_q) act_w[k] = CA_FROM_LEFT;
						else if (IW'(k) == i_q) act_w[k] = CA_LOAD;
					end
					P_MERGE: begin
						if (IW'(k) == i_q) act_w[k] = CA_MERGE_INC;
					end
					P_SPLIT: begin
						if (IW'(k) == i_q) act_w[k] = CA_END_LO;
						else if (IW'(k) == i_q + IW'(1)) act_w[k] = CA_SPLIT_HI;
						else if (IW'(k) > i_q + IW'(1)) act_w[k] = CA_FROM_LEFT;
					end
					P_TRIM: begin
						if (IW'(k) == i_q && flags_w[k].lo_gt_beg) act_w[k] = CA_END_LO;
						else if (IW'(k) == j_q - IW'(1) && flags_w[k].hi_lt_end)
							act_w[k] = CA_BEG_HI;
					end
					P_ADD:   act_w[k] = CA_ADD;
					P_SUB:   act_w[k] = CA_SUB;
					default: ;
				endcase
			end else if (state_q == S_DEL && del_cnt_q != '0) begin
				if (IW'(k) >= del_pos_q) act_w[k] = CA_FROM_RIGHT;
				else if (merge_q && IW'(k + 1) == del_pos_q) act_w[k] = CA_ABSORB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			plan_q      <= P_NONE;
			i_q         <= '0;
			j_q         <= '0;
			del_pos_q   <= '0;
			del_cnt_q   <= '0;
			merge_q     <= 1'b0;
			settle_q    <= '0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					plan_q    <= plan_c;
					i_q       <= i_c;
					j_q       <= j_c;
					del_pos_q <= del_pos_c;
					del_cnt_q <= del_cnt_c;
					merge_q   <= merge_c;
					state_q   <= S_ACT;
				end
				S_ACT: begin
					if (plan_q == P_INSERT || plan_q == P_SPLIT) cnt_q <= cnt_q + IW'(1);
					state_q <= S_DEL;
				end
				S_DEL: begin
					if (del_cnt_q != '0) begin
						del_cnt_q <= del_cnt_q - IW'(1);
						cnt_q     <= cnt_q - IW'(1);
					end else if (req_q.op == OP_INCLUDE || req_q.op == OP_EXCLUDE) begin
						settle_q <= SW'(MAX_RANGES + 1);
						state_q  <= S_SETTLE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SETTLE: begin
					if (settle_q == '0) state_q <= S_DONE;
					else settle_q <= settle_q - SW'(1);
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_q <= req;
		if (state_q == S_EVAL) begin
			status_q <= status_c;
			member_q <= (req_q.op == OP_TEST) & member_c;
			ev_q     <= (req_q.op == OP_READ) & rd_ok;
			eb_q     <= ((req_q.op == OP_READ) && rd_ok) ? 32'(rd_beg) : 32'd0;
			ee_q     <= ((req_q.op == OP_READ) && rd_ok) ? 32'(rd_end) : 32'd0;
		end
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status        <= status_q;
			rsp_q.is_member     <= member_q;
			rsp_q.entry_valid   <= ev_q;
			rsp_q.entry_begin   <= eb_q;
			rsp_q.entry_end     <= ee_q;
			rsp_q.range_count   <= 5'(cnt_q);
			rsp_q.covered_total <= sum_c[MAX_RANGES];
		end
	end

endmodule
